// ===== design/assert_macros.svh =====
// Assertion macros shared by the thruster allocation design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define TAS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Implication whose consequent is checked in the next cycle.
`define TAS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== design/tas_pkg.sv =====
// Package with types, constants and the allocation matrix of the thruster allocator.
`timescale 1ns / 1ps
package tas_pkg;

   localparam int DATA_W             = 16;
   localparam int LIMIT_W            = 15;
   localparam int OUT_COUNT          = 8;
   localparam int ROWS_MAX           = 12;
   localparam int AXES_MAX           = 6;
   localparam int THRUSTER_COUNT_DEF = 8;
   localparam int AXIS_COUNT_DEF     = 6;
   localparam int PROD_W             = 2 * DATA_W;
   localparam int QUOT_W             = DATA_W + 1;
   localparam int DVS_W              = DATA_W + 1;
   localparam int DVD_W              = PROD_W + 1;
   localparam int CSR_INDEX_W        = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_UPPER_LIMIT = 8'd0,
      CSR_LOWER_LIMIT = 8'd1
   } csr_index_type;

   typedef struct packed {
      logic                 scaled;
      logic [OUT_COUNT-1:0] neg;
   } div_side_type;

   // Q1.15 coefficients, rows past the sixth are zero.
   localparam logic signed [DATA_W-1:0] COEF [ROWS_MAX][AXES_MAX] = '{
      '{-16'sd14395,  16'sd9755,  -16'sd144, 16'sd0, 16'sd0,  16'sd4234},
      '{ 16'sd14395,  16'sd10197,  16'sd144, 16'sd0, 16'sd0, -16'sd4234},
      '{-16'sd13612, -16'sd9755,  -16'sd144, 16'sd0, 16'sd0, -16'sd4234},
      '{ 16'sd13612, -16'sd10197,  16'sd144, 16'sd0, 16'sd0,  16'sd4234},
      '{-16'sd1212,   16'sd0,    -16'sd8493, 16'sd0, 16'sd0,  16'sd433},
      '{ 16'sd1212,   16'sd0,    -16'sd9463, 16'sd0, 16'sd0, -16'sd433},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}
   };

endpackage

// ===== design/tas_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes side by side.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tas_divider
   import tas_pkg::*;
#(
   parameter int LANES  = OUT_COUNT,
   parameter int SIDE_W = $bits(div_side_type)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [LANES*DVD_W-1:0]  in_dividend,
   input  logic [LANES*DVS_W-1:0]  in_divisor,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [LANES*QUOT_W-1:0] out_quotient,
   output logic [SIDE_W-1:0]       out_side
);

   localparam int STAGES = QUOT_W + 1;
   localparam int HIGH_W = DVD_W - QUOT_W;

   logic [STAGES-1:0]  valid_ff;
   logic [STAGES:0]    ready;
   logic [DVS_W-1:0]   rem_ff  [STAGES][LANES];
   logic [QUOT_W-1:0]  low_ff  [STAGES][LANES];
   logic [DVS_W-1:0]   dvs_ff  [STAGES][LANES];
   logic [SIDE_W-1:0]  side_ff [STAGES];

   assign ready[STAGES] = out_ready;
   assign in_ready      = ready[0];
   assign out_valid     = valid_ff[STAGES-1];
   assign out_side      = side_ff[STAGES-1];

   genvar k, l;
   generate
      for (k = 0; k < STAGES; k++) begin : g_stage
         assign ready[k] = !valid_ff[k] || ready[k+1];

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (ready[k]) begin
               valid_ff[k] <= (k == 0) ? in_valid : valid_ff[(k == 0) ? 0 : k-1];
            end
         end

         if (k == 0) begin : g_load
            always_ff @(posedge clock) begin
               if (ready[0]) begin
                  side_ff[0] <= in_side;
               end
            end
            for (l = 0; l < LANES; l++) begin : g_lane
               always_ff @(posedge clock) begin
                  if (ready[0]) begin
                     rem_ff[0][l] <= DVS_W'(in_dividend[l*DVD_W+QUOT_W +: HIGH_W]);
                     low_ff[0][l] <= in_dividend[l*DVD_W +: QUOT_W];
                     dvs_ff[0][l] <= in_divisor[l*DVS_W +: DVS_W];
                  end
               end
            end
         end else begin : g_step
            always_ff @(posedge clock) begin
               if (ready[k]) begin
                  side_ff[k] <= side_ff[k-1];
               end
            end
            for (l = 0; l < LANES; l++) begin : g_lane
               logic [DVS_W:0]   trial;
               logic             ge;
               logic [DVS_W:0]   diff;
               logic [DVS_W-1:0] rem_in;
               logic [QUOT_W-1:0] low_in;

               always_comb begin
                  trial  = {rem_ff[k-1][l], low_ff[k-1][l][QUOT_W-1]};
                  ge     = trial >= {1'b0, dvs_ff[k-1][l]};
                  diff   = trial - {1'b0, dvs_ff[k-1][l]};
                  rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                  low_in = {low_ff[k-1][l][QUOT_W-2:0], ge};
               end

               always_ff @(posedge clock) begin
                  if (ready[k]) begin
                     rem_ff[k][l] <= rem_in;
                     low_ff[k][l] <= low_in;
                     dvs_ff[k][l] <= dvs_ff[k-1][l];
                  end
               end

               `TAS_ASSERT_IMPL(a_rem_below_divisor, clock, reset, valid_ff[k], rem_ff[k][l] < dvs_ff[k][l])
            end
         end
      end

      for (l = 0; l < LANES; l++) begin : g_out
         assign out_quotient[l*QUOT_W +: QUOT_W] = low_ff[STAGES-1][l];
      end
   endgenerate

   `TAS_ASSERT_IMPL(a_first_rem_below_divisor, clock, reset, valid_ff[0], rem_ff[0][0] < dvs_ff[0][0])
   // A finished quotient that is not taken stays on the output.
   `TAS_ASSERT_NEXT(a_out_held, clock, reset, out_valid && !out_ready, out_valid)

endmodule

// ===== design/thruster_allocation_with_scaling_top.sv =====
// Pipeline: 7 front stages plus 18 divider stages.
// Throughput: one request per cycle unless stalled; each stage has a valid bit and moves when
// the stage after it is free, so bubbles close up while a finished result waits on rsp_tready.
// The depth is set mostly by the per-lane divider, which retires one quotient bit per stage.
// Reset (synchronous, active high) empties the pipeline and sets the limits to 32767 / -32768.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module thruster_allocation_with_scaling_top
   import tas_pkg::*;
#(
   parameter int THRUSTER_COUNT = THRUSTER_COUNT_DEF,
   parameter int AXIS_COUNT     = AXIS_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // req_tdata: surge_force, sway_force, heave_force, roll_torque, pitch_torque,
   // yaw_torque, 16 bits each from the lowest bit up.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [6*DATA_W-1:0]      req_tdata,
   // rsp_tdata: thrust_zero .. thrust_seven, 16 bits each from the lowest bit up.
   // rsp_tuser: was_scaled.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [OUT_COUNT*DATA_W-1:0] rsp_tdata,
   output logic [0:0]               rsp_tuser,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]        csr_data
);

   localparam int T      = THRUSTER_COUNT;
   localparam int A      = AXIS_COUNT;
   localparam int NSTAGE = 7;
   localparam int SUM_W  = PROD_W + 3;

   // Configuration registers; the user must write only while the pipeline is empty, unchecked.
   logic [LIMIT_W-1:0]       upper_ff;
   logic signed [DATA_W-1:0] lower_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= {LIMIT_W{1'b1}};
         lower_ff <= {1'b1, {(DATA_W-1){1'b0}}};
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_UPPER_LIMIT: upper_ff <= csr_data[LIMIT_W-1:0];
            CSR_LOWER_LIMIT: lower_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective limits: a zero upper limit acts as one, a non-negative lower limit as minus one.
   logic [DATA_W-1:0] up_lim;
   logic [DATA_W-1:0] down_lim;
   logic [DATA_W-1:0] lower_neg;

   assign lower_neg = DATA_W'(~lower_ff + 1'b1);
   assign up_lim    = (upper_ff == '0) ? DATA_W'(1) : DATA_W'(upper_ff);
   assign down_lim  = lower_ff[DATA_W-1] ? lower_neg : DATA_W'(1);

   // Stage handshake: a stage loads when it is empty or the next one loads.
   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE:0]   ready;
   logic              div_in_ready;

   assign ready[NSTAGE] = div_in_ready;
   assign req_tready    = ready[0];

   genvar s;
   generate
      for (s = 0; s < NSTAGE; s++) begin : g_ctl
         assign ready[s] = !valid_ff[s] || ready[s+1];
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (ready[s]) begin
               valid_ff[s] <= (s == 0) ? req_tvalid : valid_ff[(s == 0) ? 0 : s-1];
            end
         end
      end
   endgenerate

   // Stage 0 registers the demand vector.
   logic signed [DATA_W-1:0] demand_ff [A];

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         for (int j = 0; j < A; j++) begin
            demand_ff[j] <= req_tdata[j*DATA_W +: DATA_W];
         end
      end
   end

   // Stage 1 forms every coefficient product.
   logic signed [PROD_W-1:0] prod_ff [T][A];

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         for (int i = 0; i < T; i++) begin
            for (int j = 0; j < A; j++) begin
               prod_ff[i][j] <= PROD_W'(demand_ff[j] * COEF[i][j]);
            end
         end
      end
   end

   // Stage 2 sums each row and rounds Q.23 to Q8.8, half up.
   logic signed [DATA_W-1:0] thrust_in [T];
   logic signed [DATA_W-1:0] thrust_ff [T];

   always_comb begin
      logic signed [SUM_W-1:0] acc;
      for (int i = 0; i < T; i++) begin
         acc = SUM_W'(16384);
         for (int j = 0; j < A; j++) begin
            acc = acc + SUM_W'(prod_ff[i][j]);
         end
         thrust_in[i] = acc[15 +: DATA_W];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[2]) begin
         thrust_ff <= thrust_in;
      end
   end

   // Stage 3 splits each thrust into sign and magnitude and checks it against its limit.
   logic [DATA_W-1:0] mag3_ff  [T];
   logic [DATA_W-1:0] lim3_ff  [T];
   logic [T-1:0]      neg3_ff;
   logic [T-1:0]      over3_ff;

   always_ff @(posedge clock) begin
      if (ready[3]) begin
         for (int i = 0; i < T; i++) begin
            neg3_ff[i]  <= thrust_ff[i][DATA_W-1];
            mag3_ff[i]  <= thrust_ff[i][DATA_W-1] ? DATA_W'(~thrust_ff[i] + 1'b1)
                                                  : DATA_W'(thrust_ff[i]);
            lim3_ff[i]  <= thrust_ff[i][DATA_W-1] ? down_lim : up_lim;
            over3_ff[i] <= thrust_ff[i][DATA_W-1]
                           ? (DATA_W'(~thrust_ff[i] + 1'b1) > down_lim)
                           : (DATA_W'(thrust_ff[i]) > up_lim);
         end
      end
   end

   // Stage 4 cross-multiplies every pair of ratios so they can be compared without division.
   logic [PROD_W-1:0] cross_ff [T][T];
   logic [DATA_W-1:0] mag4_ff  [T];
   logic [DATA_W-1:0] lim4_ff  [T];
   logic [T-1:0]      neg4_ff;
   logic [T-1:0]      over4_ff;

   always_ff @(posedge clock) begin
      if (ready[4]) begin
         for (int i = 0; i < T; i++) begin
            for (int j = 0; j < T; j++) begin
               cross_ff[i][j] <= PROD_W'(mag3_ff[i] * lim3_ff[j]);
            end
         end
         mag4_ff  <= mag3_ff;
         lim4_ff  <= lim3_ff;
         neg4_ff  <= neg3_ff;
         over4_ff <= over3_ff;
      end
   end

   // Stage 5 picks the largest ratio. Tied ratios give the same scaled result, so the
   // lowest winning index is taken. Without saturation the ratio is one over one.
   logic [T-1:0]      win;
   logic [T-1:0]      pick;
   logic [DATA_W-1:0] num_in;
   logic [DATA_W-1:0] den_in;
   logic              scaled_in;
   logic [DATA_W-1:0] num_ff;
   logic [DATA_W-1:0] den_ff;
   logic              scaled_ff;
   logic [DATA_W-1:0] mag5_ff [T];
   logic [T-1:0]      neg5_ff;

   always_comb begin
      for (int i = 0; i < T; i++) begin
         win[i] = over4_ff[i];
         for (int j = 0; j < T; j++) begin
            if (j != i && over4_ff[j] && (cross_ff[i][j] < cross_ff[j][i])) begin
               win[i] = 1'b0;
            end
         end
      end
      pick      = win & (~win + 1'b1);
      scaled_in = |over4_ff;
      num_in    = '0;
      den_in    = '0;
      for (int i = 0; i < T; i++) begin
         num_in = num_in | (pick[i] ? mag4_ff[i] : '0);
         den_in = den_in | (pick[i] ? lim4_ff[i] : '0);
      end
      if (!scaled_in) begin
         num_in = DATA_W'(1);
         den_in = DATA_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ready[5]) begin
         num_ff    <= num_in;
         den_ff    <= den_in;
         scaled_ff <= scaled_in;
         mag5_ff   <= mag4_ff;
         neg5_ff   <= neg4_ff;
      end
   end

   // Stage 6 scales each output magnitude by the denominator of the ratio.
   logic [PROD_W-1:0]    lane_prod_ff [OUT_COUNT];
   logic [OUT_COUNT-1:0] lane_neg_ff;
   logic [DATA_W-1:0]    num6_ff;
   logic                 scaled6_ff;

   genvar l;
   generate
      for (l = 0; l < OUT_COUNT; l++) begin : g_lane
         if (l < T) begin : g_used
            always_ff @(posedge clock) begin
               if (ready[6]) begin
                  lane_prod_ff[l] <= PROD_W'(mag5_ff[l] * den_ff);
                  lane_neg_ff[l]  <= neg5_ff[l];
               end
            end
         end else begin : g_unused
            always_ff @(posedge clock) begin
               if (ready[6]) begin
                  lane_prod_ff[l] <= '0;
                  lane_neg_ff[l]  <= 1'b0;
               end
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (ready[6]) begin
         num6_ff    <= num_ff;
         scaled6_ff <= scaled_ff;
      end
   end

   // Rounded quotient (2*a*den + num) / (2*num), ties away from zero once the sign is back.
   logic [OUT_COUNT*DVD_W-1:0]  div_dividend;
   logic [OUT_COUNT*DVS_W-1:0]  div_divisor;
   div_side_type                div_side_in;
   div_side_type                div_side_out;
   logic [OUT_COUNT*QUOT_W-1:0] div_quotient;

   generate
      for (l = 0; l < OUT_COUNT; l++) begin : g_div_in
         assign div_dividend[l*DVD_W +: DVD_W] = {lane_prod_ff[l], 1'b0} + DVD_W'(num6_ff);
         assign div_divisor[l*DVS_W +: DVS_W]  = {num6_ff, 1'b0};
      end
   endgenerate

   assign div_side_in.scaled = scaled6_ff;
   assign div_side_in.neg    = lane_neg_ff;

   tas_divider #(
      .LANES  (OUT_COUNT),
      .SIDE_W ($bits(div_side_type))
   ) u_divider (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (valid_ff[NSTAGE-1]),
      .in_ready     (div_in_ready),
      .in_dividend  (div_dividend),
      .in_divisor   (div_divisor),
      .in_side      (div_side_in),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_quotient (div_quotient),
      .out_side     (div_side_out)
   );

   // Put the sign back and clamp into the 16-bit result.
   generate
      for (l = 0; l < OUT_COUNT; l++) begin : g_out
         logic [QUOT_W-1:0]        q;
         logic signed [QUOT_W:0]   sv;
         logic signed [DATA_W-1:0] res;

         always_comb begin
            q  = div_quotient[l*QUOT_W +: QUOT_W];
            sv = div_side_out.neg[l] ? -$signed({1'b0, q}) : $signed({1'b0, q});
            if (sv > $signed((QUOT_W+1)'(32767))) begin
               res = 16'sh7fff;
            end else if (sv < -$signed((QUOT_W+1)'(32768))) begin
               res = 16'sh8000;
            end else begin
               res = sv[DATA_W-1:0];
            end
         end

         assign rsp_tdata[l*DATA_W +: DATA_W] = res;
      end
   endgenerate

   assign rsp_tuser[0] = div_side_out.scaled;

   // A selected ratio comes from a saturated thruster, so it is always above one.
   `TAS_ASSERT_IMPL(a_ratio_above_one, clock, reset, valid_ff[5] && scaled_ff, num_ff > den_ff)
   // Without saturation the ratio passes as exactly one.
   `TAS_ASSERT_IMPL(a_unit_ratio, clock, reset, valid_ff[5] && !scaled_ff, (num_ff == DATA_W'(1)) && (den_ff == DATA_W'(1)))
   // A request held at the divider entry stays there until the divider takes it.
   `TAS_ASSERT_NEXT(a_entry_held, clock, reset, valid_ff[NSTAGE-1] && !div_in_ready, valid_ff[NSTAGE-1])

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the thruster allocator with proportional saturation.
`timescale 1ns / 1ps
module tb;
   import tas_pkg::*;

   localparam int LATENCY     = 25;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [6*DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_COUNT*DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_data = '0;

   // One expected result: eight packed thrusts plus the scaling flag.
   typedef struct packed {
      logic [OUT_COUNT*DATA_W-1:0] thrusts;
      logic                        scaled;
   } allocation_type;

   // One directed row: six demands, and optionally a typed-in expectation.
   typedef struct {
      logic signed [DATA_W-1:0] demand [6];
      bit                       typed;
      allocation_type           result;
   } demand_row_type;

   allocation_type expected_allocations [$];
   int   fail_count   = 0;
   int   result_count = 0;
   int   scaled_count = 0;
   int   cycle_count  = 0;
   bit   hold_off     = 1'b0;
   logic [LIMIT_W-1:0]       upper_shadow = 15'd32767;
   logic signed [DATA_W-1:0] lower_shadow = -16'sd32768;

   always #4 clock = ~clock;

   thruster_allocation_with_scaling_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Allocation matrix in Q1.15, the same numbers the vehicle geometry gives.
   function automatic longint matrix_entry(int row, int col);
      longint m [6][6];
      m = '{'{-14395,  9755, -144, 0, 0,  4234},
            '{ 14395, 10197,  144, 0, 0, -4234},
            '{-13612, -9755, -144, 0, 0, -4234},
            '{ 13612,-10197,  144, 0, 0,  4234},
            '{ -1212,     0,-8493, 0, 0,   433},
            '{  1212,     0,-9463, 0, 0,  -433}};
      return (row < 6) ? m[row][col] : 0;
   endfunction

   // Computes the scaled thrust vector for one demand under the current limits.
   function automatic allocation_type allocate_thrust(logic [6*DATA_W-1:0] packed_demand);
      longint thrust [OUT_COUNT];
      longint up, down, num, den, sum, x, n, d, a, q;
      bit     over, scaled;
      allocation_type r;
      up = (upper_shadow == 0) ? 1 : longint'(upper_shadow);
      down = (lower_shadow >= 0) ? 1 : -longint'(lower_shadow);
      num = 1;
      den = 1;
      scaled = 1'b0;
      for (int i = 0; i < OUT_COUNT; i++) begin
         sum = 0;
         for (int j = 0; j < 6; j++)
            sum += longint'($signed(packed_demand[j*DATA_W +: DATA_W])) * matrix_entry(i, j);
         // Round the Q.23 sum to Q8.8 with a floor division.
         x = sum + 16384;
         thrust[i] = (x >= 0) ? x / 32768 : -((-x + 32767) / 32768);
      end
      for (int i = 0; i < OUT_COUNT; i++) begin
         over = 1'b0;
         n = 0;
         d = 1;
         if (thrust[i] > up) begin
            n = thrust[i];
            d = up;
            over = 1'b1;
         end else if (thrust[i] < -down) begin
            n = -thrust[i];
            d = down;
            over = 1'b1;
         end
         if (over) begin
            scaled = 1'b1;
            if (n * den > num * d) begin
               num = n;
               den = d;
            end
         end
      end
      for (int i = 0; i < OUT_COUNT; i++) begin
         if (scaled) begin
            a = (thrust[i] < 0) ? -thrust[i] : thrust[i];
            q = (2 * a * den + num) / (2 * num);
            thrust[i] = (thrust[i] < 0) ? -q : q;
         end
         if (thrust[i] > 32767) thrust[i] = 32767;
         if (thrust[i] < -32768) thrust[i] = -32768;
         r.thrusts[i*DATA_W +: DATA_W] = thrust[i][DATA_W-1:0];
      end
      r.scaled = scaled;
      return r;
   endfunction

   // Cycle counter and timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  expected_allocations.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: stalls on a pattern of its own, with one long hold-off on request.
   initial begin : receiver
      int phase;
      phase = 0;
      @(posedge clock);
      while (1) begin
         @(posedge clock);
         phase = phase + 1;
         if (hold_off)
            rsp_tready <= 1'b0;
         else if ((phase / 300) % 3 == 0)
            rsp_tready <= 1'b1;
         else
            rsp_tready <= ($urandom_range(0, 3) != 0) && ((phase % 7) != 3);
      end
   end

   // Checker: every accepted result is matched against the oldest expectation.
   always @(posedge clock) begin
      allocation_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count <= result_count + 1;
         if (expected_allocations.size() == 0) begin
            $display("%0t: unexpected result %h / %b", $time, rsp_tdata, rsp_tuser);
            fail_count = fail_count + 1;
         end else begin
            want = expected_allocations.pop_front();
            if (want.scaled) scaled_count <= scaled_count + 1;
            for (int i = 0; i < OUT_COUNT; i++)
               if (rsp_tdata[i*DATA_W +: DATA_W] !== want.thrusts[i*DATA_W +: DATA_W]) begin
                  $display("%0t: thrust %0d expected %0d actual %0d", $time, i,
                           $signed(want.thrusts[i*DATA_W +: DATA_W]),
                           $signed(rsp_tdata[i*DATA_W +: DATA_W]));
                  fail_count = fail_count + 1;
               end
            if (rsp_tuser[0] !== want.scaled) begin
               $display("%0t: was_scaled expected %b actual %b", $time, want.scaled,
                        rsp_tuser[0]);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   // Writes one limit register and mirrors it in the predictor.
   task automatic write_limit(csr_index_type index, logic [DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_UPPER_LIMIT)
         upper_shadow = value[LIMIT_W-1:0];
      else if (index == CSR_LOWER_LIMIT)
         lower_shadow = value;
      @(posedge clock);
   endtask

   // Offers one request and records its expectation when it is accepted.
   task automatic send_demand(logic [6*DATA_W-1:0] value, bit typed, allocation_type typed_result);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      expected_allocations.push_back(typed ? typed_result : allocate_thrust(value));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_allocations.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic [6*DATA_W-1:0] random_demand(int style);
      logic [6*DATA_W-1:0] v;
      for (int j = 0; j < 6; j++)
         case (style)
            0: v[j*DATA_W +: DATA_W] = DATA_W'($urandom);
            1: v[j*DATA_W +: DATA_W] = DATA_W'($signed($urandom_range(0, 1600)) - 800);
            default: v[j*DATA_W +: DATA_W] = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
         endcase
      return v;
   endfunction

   initial begin : stimulus
      demand_row_type rows [$];
      demand_row_type row;
      allocation_type zero_result;
      logic [6*DATA_W-1:0] value;
      int burst;

      zero_result = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: all-zero demand (known zero result), each axis alone at its
      // most positive and negative value, all axes at both extremes, one mixed row.
      row.demand = '{0, 0, 0, 0, 0, 0};
      row.typed  = 1'b1;
      row.result = zero_result;
      rows.push_back(row);
      for (int j = 0; j < 6; j++) begin
         row.demand = '{0, 0, 0, 0, 0, 0};
         row.typed  = 1'b0;
         row.demand[j] = 16'sh7FFF;
         rows.push_back(row);
         row.demand[j] = -16'sh8000;
         rows.push_back(row);
      end
      row.demand = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
      rows.push_back(row);
      row.demand = '{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000};
      rows.push_back(row);
      row.demand = '{16'sh0100, -16'sh0080, 16'sh0040, 16'sh0000, 16'sh0000, -16'sh0200};
      rows.push_back(row);

      foreach (rows[k]) begin
         for (int j = 0; j < 6; j++) value[j*DATA_W +: DATA_W] = rows[k].demand[j];
         send_demand(value, rows[k].typed, rows[k].result);
      end
      drain_results();

      // Tight limits, including the zero and non-negative corner cases that the block
      // treats as one and minus one. Directed rows but the first repeat per setting.
      for (int setting = 0; setting < 4; setting++) begin
         case (setting)
            0: begin write_limit(CSR_UPPER_LIMIT, 16'd1); write_limit(CSR_LOWER_LIMIT, -16'sd1); end
            1: begin write_limit(CSR_UPPER_LIMIT, 16'd0); write_limit(CSR_LOWER_LIMIT, 16'sd0); end
            2: begin write_limit(CSR_UPPER_LIMIT, 16'hFFFF); write_limit(CSR_LOWER_LIMIT, 16'sh7FFF); end
            default: begin
               write_limit(CSR_UPPER_LIMIT, 16'd256);
               write_limit(CSR_LOWER_LIMIT, -16'sd512);
               // Writes to unknown indexes must leave both limits alone.
               write_limit(csr_index_type'(8'd2), 16'd5);
               write_limit(csr_index_type'(8'd255), 16'd7);
            end
         endcase
         for (int k = 1; k < rows.size(); k++) begin
            for (int j = 0; j < 6; j++) value[j*DATA_W +: DATA_W] = rows[k].demand[j];
            send_demand(value, 1'b0, zero_result);
         end
         drain_results();
      end

      // Random part in phases, each but the last under a new pair of random limits.
      // The sender works in bursts with gaps; phase zero also holds the receiver off.
      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 9) begin
            write_limit(CSR_UPPER_LIMIT, 16'd32767);
            write_limit(CSR_LOWER_LIMIT, -16'sd32768);
         end else begin
            write_limit(CSR_UPPER_LIMIT, DATA_W'($urandom_range(1, 32767)));
            write_limit(CSR_LOWER_LIMIT, DATA_W'(-$signed($urandom_range(1, 32768))));
         end
         if (phase == 0) begin
            fork
               begin
                  hold_off = 1'b1;
                  repeat (200) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < RANDOM_ITEMS / 10; n += burst) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++)
               send_demand(random_demand($urandom_range(0, 5) % 3), 1'b0, zero_result);
            if ($urandom_range(0, 2) != 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
         // Pause until every expected result is back before the next setting.
         drain_results();
      end

      $display("Covered %0d results, %0d with proportional scaling,", result_count, scaled_count);
      $display("over limit extremes, zero and non-negative limits and unknown indexes.");
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
